@@ sv/qsdc_pkg.sv @@
// qsdc_pkg: shared widths, constants, the window flag struct and quality helpers
// used by the window comparator, the step controller and the top level
// no dependencies
package qsdc_pkg;

    localparam int unsigned TIME_W   = 64;
    localparam int unsigned QUAL_W   = 7;
    localparam int unsigned STEP_W   = 2;
    localparam int unsigned COUNT_W  = 3;
    localparam int unsigned CFG_IDX_W  = 1;
    localparam int unsigned CFG_DATA_W = 7;
    localparam int unsigned S_DATA_W = 192;
    localparam int unsigned M_DATA_W = 16;

    localparam logic [QUAL_W-1:0]  QUAL_MAX    = 7'd100;
    localparam logic [QUAL_W-1:0]  QUAL_MIN    = 7'd1;
    localparam logic [QUAL_W-1:0]  QUAL_RESET  = 7'd60;
    localparam logic [QUAL_W-1:0]  STEP_DROP_1 = 7'd5;
    localparam logic [QUAL_W-1:0]  STEP_DROP_2 = 7'd10;
    localparam logic [STEP_W-1:0]  STEP_FULL   = 2'd0;
    localparam logic [STEP_W-1:0]  STEP_MINUS5 = 2'd1;
    localparam logic [STEP_W-1:0]  STEP_LAST   = 2'd2;
    localparam logic [COUNT_W-1:0] CALM_TARGET = 3'd5;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_BASE_QUALITY = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_ADAPT_ENABLE = 1'b1;

    // classification of one measurement window
    typedef struct packed {
        logic skip;      // zero budget, leave state alone
        logic overload;
        logic calm;
    } qsdc_flags_t;

    function automatic logic [QUAL_W-1:0] step_quality(
        input logic [QUAL_W-1:0] base,
        input logic [STEP_W-1:0] step
    );
        logic [QUAL_W-1:0] q;
        begin
            if (step == STEP_FULL)
            begin
                q = base;
            end
            else if (step == STEP_MINUS5)
            begin
                q = (base > STEP_DROP_1) ? base - STEP_DROP_1 : QUAL_MIN;
            end
            else
            begin
                q = (base > STEP_DROP_2) ? base - STEP_DROP_2 : QUAL_MIN;
            end
            return q;
        end
    endfunction

    function automatic logic [QUAL_W-1:0] effective_quality(
        input logic [QUAL_W-1:0] base,
        input logic              enable,
        input logic [STEP_W-1:0] step
    );
        begin
            return enable ? step_quality(base, step) : base;
        end
    endfunction

endpackage

@@ sv/qsdc_window_cmp.sv @@
// qsdc_window_cmp: input register and two compare stages that classify a window
// as overload, calm or middle band against fractions of the budget
// depends on qsdc_pkg
module qsdc_window_cmp
    import qsdc_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic                in_stale,
    input  logic [TIME_W-1:0]   in_encode,
    input  logic [TIME_W-1:0]   in_latency,
    input  logic [TIME_W-1:0]   in_budget,
    output logic                flags_valid,
    input  logic                flags_ready,
    output qsdc_flags_t         flags
);

    // stage 0: registered request
    logic              v0_reg;
    logic              stale0_reg;
    logic [TIME_W-1:0] enc0_reg;
    logic [TIME_W-1:0] lat0_reg;
    logic [TIME_W-1:0] bud0_reg;

    // stage 1: partial compares
    logic              v1_reg;
    logic              stale1_reg;
    logic              bzero1_reg;
    logic              enc_gt1_reg;
    logic              enc_calm1_reg;
    logic              lat_ov1_reg;
    logic              lat_calm1_reg;
    logic [TIME_W-1:0] diff1_reg;
    logic [TIME_W-1:0] bud1_reg;

    // stage 2: final flags
    logic              v2_reg;
    qsdc_flags_t       flags2_reg;

    logic rdy0, rdy1, rdy2;

    assign rdy2     = !v2_reg || flags_ready;
    assign rdy1     = !v1_reg || rdy2;
    assign rdy0     = !v0_reg || rdy1;
    assign in_ready = rdy0;

    // stage 1 logic
    logic [TIME_W:0]   diff_ext;
    logic [TIME_W-1:0] enc_lo;
    logic [TIME_W:0]   lat_lo_ext;
    logic              enc_calm_c;
    logic              lat_calm_c;
    logic              lat_ov_c;

    always_comb
    begin
        diff_ext   = {1'b0, bud0_reg} - {1'b0, enc0_reg};
        enc_lo     = bud0_reg - {2'b00, bud0_reg[TIME_W-1:2]};
        enc_calm_c = enc0_reg < enc_lo;
        lat_lo_ext = {1'b0, bud0_reg} + {2'b00, bud0_reg[TIME_W-1:1]};
        // saturated upper bound: only an all-ones latency fails to be below it
        if (lat_lo_ext[TIME_W])
        begin
            lat_calm_c = (lat0_reg != {TIME_W{1'b1}});
        end
        else
        begin
            lat_calm_c = ({1'b0, lat0_reg} < lat_lo_ext);
        end
        // twice the budget, wider word so saturation comes for free
        lat_ov_c = {1'b0, lat0_reg} > {bud0_reg, 1'b0};
    end

    // stage 2 logic: enc > b - floor(b/10) <=> enc > b or 10*(b-enc+1) <= b
    logic [TIME_W+3:0] ten_diff;
    logic              enc_ov_c;
    qsdc_flags_t       flags_c;

    always_comb
    begin
        ten_diff = {1'b0, diff1_reg, 3'b000} + {3'b000, diff1_reg, 1'b0}
                 + (TIME_W+4)'(10);
        enc_ov_c = enc_gt1_reg || (ten_diff <= {4'b0000, bud1_reg});
        flags_c.skip     = bzero1_reg;
        flags_c.overload = stale1_reg || enc_ov_c || lat_ov1_reg;
        flags_c.calm     = !stale1_reg && enc_calm1_reg && lat_calm1_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            if (rdy0)
            begin
                v0_reg <= in_valid;
            end
            if (rdy1)
            begin
                v1_reg <= v0_reg;
            end
            if (rdy2)
            begin
                v2_reg <= v1_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy0 && in_valid)
        begin
            stale0_reg <= in_stale;
            enc0_reg   <= in_encode;
            lat0_reg   <= in_latency;
            bud0_reg   <= in_budget;
        end
        if (rdy1 && v0_reg)
        begin
            stale1_reg    <= stale0_reg;
            bzero1_reg    <= (bud0_reg == '0);
            enc_gt1_reg   <= diff_ext[TIME_W];
            enc_calm1_reg <= enc_calm_c;
            lat_ov1_reg   <= lat_ov_c;
            lat_calm1_reg <= lat_calm_c;
            diff1_reg     <= diff_ext[TIME_W-1:0];
            bud1_reg      <= bud0_reg;
        end
        if (rdy2 && v1_reg)
        begin
            flags2_reg <= flags_c;
        end
    end

    assign flags_valid = v2_reg;
    assign flags       = flags2_reg;

endmodule

@@ sv/qsdc_step_ctrl.sv @@
// qsdc_step_ctrl: configuration registers, step and calm count state, and the
// result register that feeds the output stream
// depends on qsdc_pkg
module qsdc_step_ctrl
    import qsdc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  flags_valid,
    output logic                  flags_ready,
    input  qsdc_flags_t           flags,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [QUAL_W-1:0]     out_quality,
    output logic                  out_changed,
    output logic [STEP_W-1:0]     out_step
);

    logic [QUAL_W-1:0]  base_reg,  base_next;
    logic               en_reg,    en_next;
    logic [STEP_W-1:0]  step_reg,  step_next;
    logic [COUNT_W-1:0] cnt_reg,   cnt_next;
    logic               ov_reg;
    logic [QUAL_W-1:0]  q_reg;
    logic               chg_reg;
    logic [STEP_W-1:0]  lvl_reg;

    logic adv;
    assign flags_ready = !ov_reg || out_ready;
    assign adv         = flags_valid && flags_ready;

    // window update of step and count
    logic [STEP_W-1:0]  step_upd;
    logic [COUNT_W-1:0] cnt_upd;
    logic [QUAL_W-1:0]  q_before;
    logic [QUAL_W-1:0]  q_after;

    always_comb
    begin
        step_upd = step_reg;
        cnt_upd  = cnt_reg;
        if (en_reg && !flags.skip)
        begin
            if (flags.overload)
            begin
                cnt_upd = '0;
                if (step_reg < STEP_LAST)
                begin
                    step_upd = step_reg + STEP_W'(1);
                end
            end
            else if (flags.calm)
            begin
                if (cnt_reg < CALM_TARGET)
                begin
                    cnt_upd = cnt_reg + COUNT_W'(1);
                    if ((cnt_upd >= CALM_TARGET) && (step_reg != STEP_FULL))
                    begin
                        step_upd = step_reg - STEP_W'(1);
                        cnt_upd  = '0;
                    end
                end
            end
            else
            begin
                cnt_upd = '0;
            end
        end
        q_before = effective_quality(base_reg, en_reg, step_reg);
        q_after  = effective_quality(base_reg, en_reg, step_upd);
    end

    // configuration write that changes a value takes priority over the window update
    logic [QUAL_W-1:0] cfg_base;
    logic              cfg_en;
    logic              cfg_hit;

    always_comb
    begin
        cfg_base = base_reg;
        cfg_en   = en_reg;
        cfg_hit  = 1'b0;
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_BASE_QUALITY:
                begin
                    if (cfg_data != '0)
                    begin
                        cfg_hit  = 1'b1;
                        cfg_base = (cfg_data > QUAL_MAX) ? QUAL_MAX : cfg_data;
                    end
                end
                REG_ADAPT_ENABLE:
                begin
                    cfg_hit = 1'b1;
                    cfg_en  = cfg_data[0];
                end
                default:
                begin
                    cfg_hit = 1'b0;
                end
            endcase
        end

        base_next = base_reg;
        en_next   = en_reg;
        step_next = step_reg;
        cnt_next  = cnt_reg;
        if (cfg_hit && ((cfg_base != base_reg) || (cfg_en != en_reg)))
        begin
            base_next = cfg_base;
            en_next   = cfg_en;
            step_next = '0;
            cnt_next  = '0;
        end
        else if (adv)
        begin
            step_next = step_upd;
            cnt_next  = cnt_upd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg <= QUAL_RESET;
            en_reg   <= 1'b0;
            step_reg <= '0;
            cnt_reg  <= '0;
            ov_reg   <= 1'b0;
        end
        else
        begin
            base_reg <= base_next;
            en_reg   <= en_next;
            step_reg <= step_next;
            cnt_reg  <= cnt_next;
            if (flags_ready)
            begin
                ov_reg <= flags_valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            q_reg   <= q_after;
            chg_reg <= (q_after != q_before);
            lvl_reg <= step_upd;
        end
    end

    assign out_valid   = ov_reg;
    assign out_quality = q_reg;
    assign out_changed = chg_reg;
    assign out_step    = lvl_reg;

    // step never passes the lowest level
    a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
        step_reg <= STEP_LAST)
        else $error("step beyond lowest level");

    // count never runs past the calm target
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CALM_TARGET)
        else $error("calm count out of range");

    // a full calm count only stands at full quality
    a_cnt_full: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == CALM_TARGET) |-> (step_reg == STEP_FULL))
        else $error("calm count full below full quality");

    // a zero-budget window leaves the state alone
    a_skip_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (adv && flags.skip && !cfg_we) |=> ($stable(step_reg) && $stable(cnt_reg)))
        else $error("state moved on a skipped window");

    // a window moves the step by at most one level
    a_step_moves_one: assert property (@(posedge clk) disable iff (!rst_n)
        (adv && !cfg_we) |=>
        ((step_reg == $past(step_reg)) || (step_reg == $past(step_reg) + STEP_W'(1))
         || (step_reg == $past(step_reg) - STEP_W'(1))))
        else $error("step moved by more than one level");

endmodule

@@ sv/quality_step_down_controller_top.sv @@
// quality_step_down_controller_top: stream wrapper that unpacks the window request,
// classifies it and updates the quality step
// depends on qsdc_pkg, qsdc_window_cmp, qsdc_step_ctrl
//
// channel   direction  handshake          payload
// --------  ---------  -----------------  ------------------------------------------
// s_*       in         s_tvalid/s_tready  tdata: encode, latency, budget; tuser: stale
// m_*       out        m_tvalid/m_tready  tdata: quality, step level; tuser: changed
// cfg_*     in         cfg_we             cfg_index selects register, cfg_data value
//
// one request per clock while the output is not stalled; each result passes through the
// input register, two compare stages and the result register after its request is taken
// the step and calm count live in one register each and are updated when a window's flags are taken,
// so back-to-back windows see each other's effect with no gap
// stalls: every stage holds while the stage after it is full and stalled, so a
// stalled output only blocks input once all four stages are full
// reset (asynchronous, active low): base quality 60, adaptation off, step 0, count 0
module quality_step_down_controller_top
    import qsdc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    // configuration write port
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,   // 0 base quality, 1 adapt enable
    input  logic [CFG_DATA_W-1:0] cfg_data,
    // window request stream
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_DATA_W-1:0]   s_tdata,     // [63:0] encode_time_ns,
                                               // [127:64] latency_ns,
                                               // [191:128] budget_ns
    input  logic                  s_tuser,     // [0] stale flag
    // result stream
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_DATA_W-1:0]   m_tdata,     // [6:0] quality, [8:7] step_level,
                                               // [15:9] zero
    output logic                  m_tuser      // [0] changed
);

    logic        flags_valid;
    logic        flags_ready;
    qsdc_flags_t flags;

    logic [QUAL_W-1:0] quality;
    logic [STEP_W-1:0] step_level;

    // classify the window against fractions of the budget
    qsdc_window_cmp u_cmp (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .in_stale    (s_tuser),
        .in_encode   (s_tdata[TIME_W-1:0]),
        .in_latency  (s_tdata[2*TIME_W-1:TIME_W]),
        .in_budget   (s_tdata[3*TIME_W-1:2*TIME_W]),
        .flags_valid (flags_valid),
        .flags_ready (flags_ready),
        .flags       (flags)
    );

    // step state, configuration and the result register
    qsdc_step_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .flags_valid (flags_valid),
        .flags_ready (flags_ready),
        .flags       (flags),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_quality (quality),
        .out_changed (m_tuser),
        .out_step    (step_level)
    );

    // pack the result, upper bits held at zero
    assign m_tdata = {{(M_DATA_W-QUAL_W-STEP_W){1'b0}}, step_level, quality};

endmodule

@@ verif/tb_quality_step_down_controller_top.sv @@
`timescale 1ns / 1ps
// tb_quality_step_down_controller_top: self-checking bench for the quality step-down controller
// holds its own model of the step and calm count, random and directed window requests
// depends on qsdc_pkg and quality_step_down_controller_top
module tb_quality_step_down_controller_top;
    import qsdc_pkg::*;

    localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

    // one measurement window as it travels on the request stream
    typedef struct packed {
        logic              stale;
        logic [TIME_W-1:0] encode;
        logic [TIME_W-1:0] latency;
        logic [TIME_W-1:0] budget;
    } window_t;

    // one quality decision as it should leave the block
    typedef struct packed {
        logic [QUAL_W-1:0] quality;
        logic              changed;
        logic [STEP_W-1:0] step;
    } quality_result_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata = '0;
    logic                  s_tuser = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_DATA_W-1:0]   m_tdata;
    logic                  m_tuser;

    // requests waiting for the driver, decisions waiting for the block
    window_t         windows_pending[$];
    quality_result_t results_due[$];

    // model state: configuration as the block holds it, step and calm run
    logic [QUAL_W-1:0]  cur_base = QUAL_RESET;
    logic               cur_enable = 1'b0;
    logic [STEP_W-1:0]  cur_step = STEP_FULL;
    logic [COUNT_W-1:0] calm_run = '0;

    int  src_idle_pct = 0;
    int  sink_stall_pct = 0;
    int  mismatches = 0;
    logic req_taken = 1'b0;

    quality_step_down_controller_top i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always #10 clk = ~clk;

    // thresholds of one window; the doubled and one-and-a-half budgets saturate
    function automatic void window_limits(
        input  logic [TIME_W-1:0] b,
        output logic [TIME_W-1:0] enc_hi,
        output logic [TIME_W-1:0] lat_hi,
        output logic [TIME_W-1:0] enc_lo,
        output logic [TIME_W-1:0] lat_lo
    );
        enc_hi = b - b / 10;
        lat_hi = (b > TIME_MAX / 2) ? TIME_MAX : b << 1;
        enc_lo = b - b / 4;
        lat_lo = (b > TIME_MAX - b / 2) ? TIME_MAX : b + b / 2;
    endfunction

    // quality seen at the encoder for a given step, floored at the minimum
    function automatic logic [QUAL_W-1:0] level_quality(input logic [STEP_W-1:0] step);
        if (!cur_enable || step == STEP_FULL)
            return cur_base;
        if (step == STEP_MINUS5)
            return (cur_base > STEP_DROP_1) ? cur_base - STEP_DROP_1 : QUAL_MIN;
        return (cur_base > STEP_DROP_2) ? cur_base - STEP_DROP_2 : QUAL_MIN;
    endfunction

    // register write as the block sees it; a write that changes nothing keeps the step
    function automatic void apply_register(
        input logic [CFG_IDX_W-1:0]  idx,
        input logic [CFG_DATA_W-1:0] value
    );
        logic [QUAL_W-1:0] new_base;
        logic              new_enable;
        new_base = cur_base;
        new_enable = cur_enable;
        if (idx == REG_BASE_QUALITY)
        begin
            if (value == '0)
                return;
            new_base = (value > QUAL_MAX) ? QUAL_MAX : value;
        end
        else
        begin
            new_enable = value[0];
        end
        if (new_base == cur_base && new_enable == cur_enable)
            return;
        cur_base = new_base;
        cur_enable = new_enable;
        cur_step = STEP_FULL;
        calm_run = '0;
    endfunction

    // one window through the step logic, returns the decision it causes
    function automatic quality_result_t advance_window(input window_t w);
        logic [QUAL_W-1:0] q_before;
        logic [TIME_W-1:0] enc_hi, lat_hi, enc_lo, lat_lo;
        logic              overload, calm;
        quality_result_t   r;
        q_before = level_quality(cur_step);
        if (cur_enable && w.budget != '0)
        begin
            window_limits(w.budget, enc_hi, lat_hi, enc_lo, lat_lo);
            overload = w.stale || w.encode > enc_hi || w.latency > lat_hi;
            calm = !w.stale && w.encode < enc_lo && w.latency < lat_lo;
            if (overload)
            begin
                calm_run = '0;
                if (cur_step < STEP_LAST)
                    cur_step = cur_step + 1'b1;
            end
            else if (calm)
            begin
                // at full quality the run parks at the target
                if (calm_run < CALM_TARGET)
                begin
                    calm_run = calm_run + 1'b1;
                    if (calm_run == CALM_TARGET && cur_step != STEP_FULL)
                    begin
                        cur_step = cur_step - 1'b1;
                        calm_run = '0;
                    end
                end
            end
            else
            begin
                calm_run = '0;
            end
        end
        r.quality = level_quality(cur_step);
        r.changed = (r.quality != q_before);
        r.step = cur_step;
        return r;
    endfunction

    function automatic logic [TIME_W-1:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [TIME_W-1:0] pick_budget();
        int unsigned sel;
        logic [TIME_W-1:0] b;
        sel = $urandom_range(0, 9);
        if (sel < 6)
            b = TIME_W'($urandom_range(1, 40_000_000));
        else if (sel < 8)
            b = rand64();
        else
            b = TIME_W'($urandom_range(1, 40));
        return (b == '0) ? TIME_W'(1) : b;
    endfunction

    // calm window, often right at the edge of the calm band
    function automatic window_t calm_window(input logic [TIME_W-1:0] b);
        logic [TIME_W-1:0] enc_hi, lat_hi, enc_lo, lat_lo;
        window_t w;
        window_limits(b, enc_hi, lat_hi, enc_lo, lat_lo);
        w.stale = 1'b0;
        w.budget = b;
        w.encode = ($urandom_range(0, 3) == 0) ? enc_lo - 1 : rand64() % enc_lo;
        w.latency = ($urandom_range(0, 3) == 0) ? lat_lo - 1 : rand64() % lat_lo;
        return w;
    endfunction

    // overload by a stale input, a slow encode or a long latency
    function automatic window_t overload_window(input logic [TIME_W-1:0] b);
        logic [TIME_W-1:0] enc_hi, lat_hi, enc_lo, lat_lo;
        logic              edge_hit;
        int unsigned       why;
        window_t w;
        window_limits(b, enc_hi, lat_hi, enc_lo, lat_lo);
        edge_hit = ($urandom_range(0, 2) == 0);
        why = $urandom_range(0, 2);
        w.stale = (why == 0);
        w.budget = b;
        w.encode = rand64() % (enc_hi + 1);
        w.latency = rand64() % lat_lo;
        if (why == 2 && lat_hi != TIME_MAX)
            w.latency = lat_hi + 1 + (edge_hit ? '0 : rand64() % (TIME_MAX - lat_hi));
        else if (why != 0)
            w.encode = enc_hi + 1 + (edge_hit ? '0 : rand64() % (TIME_MAX - enc_hi));
        return w;
    endfunction

    // neither calm nor overload: one of the two times sits in the middle band
    function automatic window_t middle_window(input logic [TIME_W-1:0] b);
        logic [TIME_W-1:0] enc_hi, lat_hi, enc_lo, lat_lo;
        window_t w;
        window_limits(b, enc_hi, lat_hi, enc_lo, lat_lo);
        w.stale = 1'b0;
        w.budget = b;
        if ($urandom_range(0, 1) == 0)
        begin
            w.encode = enc_lo + rand64() % (enc_hi - enc_lo + 1);
            w.latency = rand64() % lat_lo;
        end
        else
        begin
            w.encode = rand64() % enc_lo;
            w.latency = lat_lo + rand64() % (lat_hi - lat_lo + 1);
        end
        return w;
    endfunction

    task automatic push_window(
        input logic              stale,
        input logic [TIME_W-1:0] encode,
        input logic [TIME_W-1:0] latency,
        input logic [TIME_W-1:0] budget
    );
        window_t w;
        w.stale = stale;
        w.encode = encode;
        w.latency = latency;
        w.budget = budget;
        windows_pending.push_back(w);
    endtask

    // mostly runs of calm windows so the step climbs back, broken by overloads,
    // middle windows and unshaped noise
    task automatic queue_random(input int n);
        int left;
        int sel;
        int len;
        window_t w;
        logic [TIME_W-1:0] b;
        left = n;
        while (left > 0)
        begin
            sel = $urandom_range(0, 99);
            b = pick_budget();
            if (sel < 55)
            begin
                len = $urandom_range(3, 7);
                for (int i = 0; i < len; i++)
                    windows_pending.push_back(calm_window(b));
                left -= len;
            end
            else
            begin
                if (sel < 75)
                    w = overload_window(b);
                else if (sel < 88)
                    w = middle_window(b);
                else
                begin
                    w.stale = 1'($urandom_range(0, 1));
                    w.encode = rand64();
                    w.latency = rand64();
                    w.budget = ($urandom_range(0, 3) == 0) ? '0 : rand64();
                end
                windows_pending.push_back(w);
                left--;
            end
        end
    endtask

    // register write at a falling edge, taken at the rising edge after it
    task automatic write_reg(
        input logic [CFG_IDX_W-1:0]  idx,
        input logic [CFG_DATA_W-1:0] value
    );
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        apply_register(idx, value);
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_traffic(input int src_pct, input int sink_pct);
        src_idle_pct = src_pct;
        sink_stall_pct = sink_pct;
    endtask

    // wait for every request to be taken and every decision to come back,
    // then let the four-stage pipe run empty before touching the registers
    task automatic settle();
        while (windows_pending.size() != 0 || s_tvalid || results_due.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    function automatic void check_field(
        input string             field,
        input logic [TIME_W-1:0] expected,
        input logic [TIME_W-1:0] actual
    );
        if (expected !== actual)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d",
                     $time, field, expected, actual);
            mismatches++;
        end
    endfunction

    // request driver: holds a request until it is taken, idles at random
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!s_tvalid || req_taken)
            begin
                if (windows_pending.size() != 0 && $urandom_range(0, 99) >= src_idle_pct)
                begin
                    window_t w;
                    w = windows_pending.pop_front();
                    s_tvalid <= 1'b1;
                    s_tuser <= w.stale;
                    s_tdata <= {w.budget, w.latency, w.encode};
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
            m_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
        end
    end

    // monitor: model runs on every taken request, every decision is checked in order
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            req_taken = s_tvalid && s_tready;
            if (req_taken)
            begin
                window_t w;
                w.stale = s_tuser;
                w.encode = s_tdata[TIME_W-1:0];
                w.latency = s_tdata[2*TIME_W-1:TIME_W];
                w.budget = s_tdata[3*TIME_W-1:2*TIME_W];
                results_due.push_back(advance_window(w));
            end
            if (m_tvalid && m_tready)
            begin
                if (results_due.size() == 0)
                begin
                    $display("%0t: decision with none expected, actual quality %0d step %0d",
                             $time, m_tdata[QUAL_W-1:0], m_tdata[QUAL_W+STEP_W-1:QUAL_W]);
                    mismatches++;
                end
                else
                begin
                    quality_result_t r;
                    r = results_due.pop_front();
                    check_field("quality", TIME_W'(r.quality),
                                TIME_W'(m_tdata[QUAL_W-1:0]));
                    check_field("step_level", TIME_W'(r.step),
                                TIME_W'(m_tdata[QUAL_W+STEP_W-1:QUAL_W]));
                    check_field("changed", TIME_W'(r.changed), TIME_W'(m_tuser));
                    check_field("tdata padding", '0,
                                TIME_W'(m_tdata[M_DATA_W-1:QUAL_W+STEP_W]));
                end
            end
        end
    end

    // run limit, well beyond the slowest correct run
    initial
    begin
        #5_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // adaptation off after reset: the base quality passes straight through
        set_traffic(0, 0);
        push_window(1'b1, TIME_MAX, TIME_MAX, 64'd1000);
        push_window(1'b0, '0, '0, '0);
        queue_random(30);
        settle();

        // directed walk with a budget of 1000: overload above 900 encode or
        // 2000 latency, calm below 750 encode and 1500 latency
        write_reg(REG_ADAPT_ENABLE, 7'h7F);
        push_window(1'b0, '0, '0, '0);                  // zero budget skips
        push_window(1'b1, '0, '0, '0);                  // stale but zero budget
        push_window(1'b1, '0, '0, 64'd1000);            // stale input steps down
        push_window(1'b0, 64'd901, '0, 64'd1000);       // slow encode, last step
        push_window(1'b0, '0, 64'd2001, 64'd1000);      // long latency at the floor
        push_window(1'b0, 64'd900, 64'd2000, 64'd1000); // both on the limit: middle
        repeat (5) push_window(1'b0, 64'd749, 64'd1499, 64'd1000);
        push_window(1'b0, 64'd750, '0, 64'd1000);       // encode on calm edge: middle
        repeat (5) push_window(1'b0, '0, '0, 64'd1);    // smallest budget, back to full
        repeat (6) push_window(1'b0, '0, '0, 64'd1000); // calm run parks at full
        push_window(1'b0, TIME_MAX, '0, TIME_MAX);      // largest budget, slow encode
        push_window(1'b0, '0, TIME_MAX, {1'b1, 63'd0}); // saturated limits: middle
        settle();

        // enable rewritten unchanged keeps the step, a zero base is dropped
        write_reg(REG_ADAPT_ENABLE, 7'd1);
        write_reg(REG_BASE_QUALITY, 7'd0);
        set_traffic(81, 0);
        queue_random(250);
        settle();

        // base above the top clamps to 100
        write_reg(REG_BASE_QUALITY, 7'd127);
        set_traffic(0, 81);
        queue_random(250);
        settle();

        // same clamped value again is a no-op, then a base below both drops
        write_reg(REG_BASE_QUALITY, 7'd101);
        write_reg(REG_BASE_QUALITY, 7'd3);
        set_traffic(19, 19);
        queue_random(200);
        settle();

        write_reg(REG_BASE_QUALITY, 7'd1);
        set_traffic(0, 0);
        queue_random(150);
        settle();

        write_reg(REG_BASE_QUALITY, 7'd11);
        set_traffic(81, 0);
        queue_random(150);
        settle();

        // adaptation off again with the top quality
        write_reg(REG_ADAPT_ENABLE, 7'd0);
        write_reg(REG_BASE_QUALITY, 7'd100);
        set_traffic(0, 81);
        queue_random(100);
        settle();

        write_reg(REG_BASE_QUALITY, 7'd60);
        write_reg(REG_ADAPT_ENABLE, 7'd1);
        set_traffic(19, 19);
        queue_random(150);
        settle();

        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

@@ sim.f @@
sv/qsdc_pkg.sv
sv/qsdc_window_cmp.sv
sv/qsdc_step_ctrl.sv
sv/quality_step_down_controller_top.sv
verif/tb_quality_step_down_controller_top.sv
